[design/gbm_pkg.sv]
package gbm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int STATE_W = 48;
	localparam int COEF_W = 17;
	localparam int SCOEF_W = 16;
	localparam int BLEN_W = 13;
	localparam int MAX_BLOCK_LENGTH = 4096;
	localparam int MIN_BLOCK_LENGTH = 2;
	localparam int MAG_W = 32;
	localparam int CFG_W = 17;
	localparam int CFG_IDX_W = 2;

	// state split into two halves for the shared multiplier
	localparam int HALF_W = STATE_W / 2;
	localparam int MUL_A_W = HALF_W + 1;
	localparam int PROD_W = MUL_A_W + COEF_W;
	localparam int ACC_W = STATE_W + COEF_W + 1;
	localparam int FRAC_W = 14;
	localparam int RND_W = ACC_W - FRAC_W;
	localparam int WIDE_W = RND_W + 1;
	// |real|, |imag| stay below 2^49
	localparam int RI_W = 50;

	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_AW = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TWO_COS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIN = 2'd3;

	localparam logic [BLEN_W-1:0] RST_BLOCK_LENGTH = 13'd256;
	localparam logic [COEF_W-1:0] RST_TWO_COS = 17'd32768;
	localparam logic [SCOEF_W-1:0] RST_COS = 16'd16384;
	localparam logic [SCOEF_W-1:0] RST_SIN = 16'd0;

	typedef struct packed {
		logic [BLEN_W-1:0] block_length;
		logic [COEF_W-1:0] two_cos_coeff;
		logic [SCOEF_W-1:0] cos_coeff;
		logic [SCOEF_W-1:0] sin_coeff;
	} cfg_t;

	typedef struct packed {
		logic [RI_W-1:0] re;
		logic [RI_W-1:0] im;
	} ri_t;

	typedef struct packed {
		logic [FIFO_CW-1:0] count;
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

[design/gbm_front.sv]
module gbm_front (
	input  logic clk,
	input  logic arst_n,
	input  gbm_pkg::cfg_t cfg,
	input  logic sample_valid,
	output logic sample_ready,
	input  logic [gbm_pkg::SAMPLE_W-1:0] sample,
	output logic push_valid,
	input  logic push_ready,
	output gbm_pkg::ri_t push_data
);

	typedef enum logic [9:0] {
		F_IDLE    = 10'b00_0000_0001,
		F_REC_LO  = 10'b00_0000_0010,
		F_REC_HI  = 10'b00_0000_0100,
		F_REC_UPD = 10'b00_0000_1000,
		F_COS_LO  = 10'b00_0001_0000,
		F_COS_HI  = 10'b00_0010_0000,
		F_RE      = 10'b00_0100_0000,
		F_SIN_LO  = 10'b00_1000_0000,
		F_SIN_HI  = 10'b01_0000_0000,
		F_PUSH    = 10'b10_0000_0000
	} fstate_t;

	localparam int SW = gbm_pkg::STATE_W;
	localparam int HW = gbm_pkg::HALF_W;
	localparam int AW = gbm_pkg::ACC_W;
	localparam int PW = gbm_pkg::PROD_W;
	localparam int WW = gbm_pkg::WIDE_W;
	localparam int RW = gbm_pkg::RND_W;
	localparam int XW = gbm_pkg::SAMPLE_W;
	localparam int CW = gbm_pkg::COEF_W;
	localparam int BW = gbm_pkg::BLEN_W;

	fstate_t state_q;
	logic signed [SW-1:0] q1_q, q2_q;
	logic signed [XW-1:0] x_q;
	logic [BW-1:0] count_q;
	logic signed [AW-1:0] acc_q;
	logic signed [gbm_pkg::RI_W-1:0] re_q;

	logic signed [SW-1:0] mul_v;
	logic signed [gbm_pkg::MUL_A_W-1:0] mul_a;
	logic signed [CW-1:0] mul_c;
	logic signed [PW-1:0] prod;
	logic signed [AW-1:0] prod_ext;
	logic signed [AW-1:0] acc_rnd;
	logic signed [RW-1:0] rnd;
	logic signed [WW-1:0] q0_wide, re_wide;
	logic signed [SW-1:0] q0_sat;
	logic q0_ovf;
	logic lo_sel;
	logic [BW-1:0] len_eff, cnt_next;
	logic blk_end;

	// operand select for the shared 25x17 multiplier
	always_comb begin
		lo_sel = (state_q == F_REC_LO) || (state_q == F_COS_LO) || (state_q == F_SIN_LO);
		case (state_q)
			F_REC_LO, F_REC_HI: begin
				mul_v = q1_q;
				mul_c = $signed(cfg.two_cos_coeff);
			end
			F_COS_LO, F_COS_HI: begin
				mul_v = q2_q;
				mul_c = CW'($signed(cfg.cos_coeff));
			end
			default: begin
				mul_v = q2_q;
				mul_c = CW'($signed(cfg.sin_coeff));
			end
		endcase
		if (lo_sel)
			mul_a = $signed({1'b0, mul_v[HW-1:0]});
		else
			mul_a = $signed({mul_v[SW-1], mul_v[SW-1:HW]});
	end

	assign prod = mul_a * mul_c;
	assign prod_ext = AW'(prod);

	// round to nearest, ties up: floor((v*c + 2^13) / 2^14)
	assign acc_rnd = (acc_q + AW'(1 << (gbm_pkg::FRAC_W - 1))) >>> gbm_pkg::FRAC_W;
	assign rnd = acc_rnd[RW-1:0];

	assign q0_wide = WW'(rnd) - WW'(q2_q) + WW'(x_q);
	assign q0_ovf = !((&q0_wide[WW-1:SW-1]) || !(|q0_wide[WW-1:SW-1]));
	always_comb begin
		if (q0_ovf)
			q0_sat = q0_wide[WW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		else
			q0_sat = q0_wide[SW-1:0];
	end
	assign re_wide = WW'(q1_q) - WW'(rnd);

	always_comb begin
		if (cfg.block_length < BW'(gbm_pkg::MIN_BLOCK_LENGTH))
			len_eff = BW'(gbm_pkg::MIN_BLOCK_LENGTH);
		else if (cfg.block_length > BW'(gbm_pkg::MAX_BLOCK_LENGTH))
			len_eff = BW'(gbm_pkg::MAX_BLOCK_LENGTH);
		else
			len_eff = cfg.block_length;
	end
	assign cnt_next = count_q + 1'b1;
	assign blk_end = cnt_next >= len_eff;

	assign sample_ready = (state_q == F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_data.re = re_q;
	assign push_data.im = rnd[gbm_pkg::RI_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			q1_q <= '0;
			q2_q <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (sample_valid)
						state_q <= F_REC_LO;
				end
				F_REC_LO: state_q <= F_REC_HI;
				F_REC_HI: state_q <= F_REC_UPD;
				F_REC_UPD: begin
					q2_q <= q1_q;
					q1_q <= q0_sat;
					if (blk_end) begin
						state_q <= F_COS_LO;
					end else begin
						count_q <= cnt_next;
						state_q <= F_IDLE;
					end
				end
				F_COS_LO: state_q <= F_COS_HI;
				F_COS_HI: state_q <= F_RE;
				F_RE: state_q <= F_SIN_LO;
				F_SIN_LO: state_q <= F_SIN_HI;
				F_SIN_HI: state_q <= F_PUSH;
				F_PUSH: begin
					if (push_ready) begin
						q1_q <= '0;
						q2_q <= '0;
						count_q <= '0;
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid)
			x_q <= sample;
		if (lo_sel)
			acc_q <= prod_ext;
		else if ((state_q == F_REC_HI) || (state_q == F_COS_HI) || (state_q == F_SIN_HI))
			acc_q <= acc_q + (prod_ext <<< HW);
		if (state_q == F_RE)
			re_q <= re_wide[gbm_pkg::RI_W-1:0];
	end

endmodule

[design/gbm_fifo.sv]
module gbm_fifo (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  gbm_pkg::ri_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output gbm_pkg::ri_t pop_data,
	output gbm_pkg::fifo_stat_t stat
);

	gbm_pkg::ri_t mem_q [gbm_pkg::FIFO_DEPTH];
	logic [gbm_pkg::FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [gbm_pkg::FIFO_CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign push_ready = cnt_q != gbm_pkg::FIFO_CW'(gbm_pkg::FIFO_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	assign stat.count = cnt_q;
	assign stat.full = !push_ready;
	assign stat.empty = !pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

endmodule

[design/gbm_back.sv]
module gbm_back (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop_ready,
	input  gbm_pkg::ri_t pop_data,
	output logic magnitude_valid,
	input  logic magnitude_ready,
	output logic [gbm_pkg::MAG_W-1:0] magnitude
);

	typedef enum logic [6:0] {
		B_IDLE  = 7'b000_0001,
		B_CHECK = 7'b000_0010,
		B_SQA   = 7'b000_0100,
		B_SQB   = 7'b000_1000,
		B_SUM   = 7'b001_0000,
		B_ROOT  = 7'b010_0000,
		B_FIN   = 7'b100_0000
	} bstate_t;

	localparam int MW = gbm_pkg::MAG_W;
	localparam int RIW = gbm_pkg::RI_W;
	localparam int SQW = 2 * MW;
	localparam int REMW = MW + 3;
	localparam int ITW = $clog2(MW);

	bstate_t state_q;
	gbm_pkg::ri_t ri_q;
	logic [MW-1:0] a_q, b_q;
	logic [SQW-1:0] sqa_q, sqb_q, rad_q;
	logic [REMW-1:0] rem_q;
	logic [MW-1:0] root_q;
	logic [ITW-1:0] iter_q;
	logic out_valid_q;
	logic [MW-1:0] mag_q;

	logic [RIW-1:0] abs_re, abs_im;
	logic too_big;
	logic [SQW:0] sum;
	logic [REMW-1:0] rem_sh, trial;
	logic fit;
	logic load_out;

	assign abs_re = ri_q.re[RIW-1] ? RIW'(-ri_q.re) : ri_q.re;
	assign abs_im = ri_q.im[RIW-1] ? RIW'(-ri_q.im) : ri_q.im;
	assign too_big = (|abs_re[RIW-1:MW]) || (|abs_im[RIW-1:MW]);
	assign sum = {1'b0, sqa_q} + {1'b0, sqb_q};

	// restoring square root, one result bit per cycle
	assign rem_sh = {rem_q[REMW-3:0], rad_q[SQW-1:SQW-2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fit = rem_sh >= trial;

	assign pop_ready = (state_q == B_IDLE);
	assign load_out = (state_q == B_FIN) && (!out_valid_q || magnitude_ready);
	assign magnitude_valid = out_valid_q;
	assign magnitude = mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out)
				out_valid_q <= 1'b1;
			else if (magnitude_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop_valid)
						state_q <= B_CHECK;
				end
				B_CHECK: state_q <= too_big ? B_FIN : B_SQA;
				B_SQA: state_q <= B_SQB;
				B_SQB: state_q <= B_SUM;
				B_SUM: state_q <= sum[SQW] ? B_FIN : B_ROOT;
				B_ROOT: begin
					if (iter_q == ITW'(MW - 1))
						state_q <= B_FIN;
				end
				B_FIN: begin
					if (load_out)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop_valid)
					ri_q <= pop_data;
			end
			B_CHECK: begin
				a_q <= abs_re[MW-1:0];
				b_q <= abs_im[MW-1:0];
				root_q <= '1;
			end
			B_SQA: sqa_q <= a_q * a_q;
			B_SQB: sqb_q <= b_q * b_q;
			B_SUM: begin
				rad_q <= sum[SQW-1:0];
				rem_q <= '0;
				iter_q <= '0;
				root_q <= sum[SQW] ? '1 : '0;
			end
			B_ROOT: begin
				rad_q <= rad_q << 2;
				iter_q <= iter_q + 1'b1;
				if (fit) begin
					rem_q <= rem_sh - trial;
					root_q <= {root_q[MW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					root_q <= {root_q[MW-2:0], 1'b0};
				end
			end
			default: ;
		endcase
		if (load_out)
			mag_q <= root_q;
	end

endmodule

[design/goertzel_bin_magnitude_core.sv]
// Channel    Direction  Signals                                   Width
// sample     in         sample_valid / sample_ready / sample      16 signed
// magnitude  out        magnitude_valid / magnitude_ready / mag.  32 unsigned
// config     in         cfg_we / cfg_index / cfg_data             2 / 17
//
// In the recurrence front end a sample passes through accept, two partial
// products on its shared 25x17 multiplier and a state update.
// A block's last sample also passes the cos and sin products, real part and push.
// The magnitude back end takes each block through a range check, the squares, their
// sum and a 32-step root, skipping later steps when the result saturates; a 2-entry
// queue sits between them, so it overlaps the next block's samples.
// Reset clears state, count, queue and output valid; configuration takes reset values.
// A stalled magnitude output holds the back end; the front end stalls in its push
// state once the queue is full, which runs of short blocks also reach on their own.
module goertzel_bin_magnitude_core (
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_ready,
	input  logic [gbm_pkg::SAMPLE_W-1:0] sample,
	output logic magnitude_valid,
	input  logic magnitude_ready,
	output logic [gbm_pkg::MAG_W-1:0] magnitude,
	input  logic cfg_we,
	input  logic [gbm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gbm_pkg::CFG_W-1:0] cfg_data
);

	gbm_pkg::cfg_t cfg_q;
	logic push_valid, push_ready, pop_valid, pop_ready;
	gbm_pkg::ri_t push_data, pop_data;
	gbm_pkg::fifo_stat_t fifo_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.block_length <= gbm_pkg::RST_BLOCK_LENGTH;
			cfg_q.two_cos_coeff <= gbm_pkg::RST_TWO_COS;
			cfg_q.cos_coeff <= gbm_pkg::RST_COS;
			cfg_q.sin_coeff <= gbm_pkg::RST_SIN;
		end else if (cfg_we) begin
			case (cfg_index)
				gbm_pkg::CFG_BLOCK_LENGTH: cfg_q.block_length <= cfg_data[gbm_pkg::BLEN_W-1:0];
				gbm_pkg::CFG_TWO_COS: cfg_q.two_cos_coeff <= cfg_data[gbm_pkg::COEF_W-1:0];
				gbm_pkg::CFG_COS: cfg_q.cos_coeff <= cfg_data[gbm_pkg::SCOEF_W-1:0];
				gbm_pkg::CFG_SIN: cfg_q.sin_coeff <= cfg_data[gbm_pkg::SCOEF_W-1:0];
				default: ;
			endcase
		end
	end

	gbm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	gbm_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.stat(fifo_stat)
	);

	gbm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.magnitude_valid(magnitude_valid),
		.magnitude_ready(magnitude_ready),
		.magnitude(magnitude)
	);

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_stat.count <= gbm_pkg::FIFO_CW'(gbm_pkg::FIFO_DEPTH))
		else $error("queue count above depth");

	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("front end took a sample while busy");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid && pop_ready |-> !fifo_stat.empty)
		else $error("pop from empty queue");

	a_push_space: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && fifo_stat.full |=> push_valid)
		else $error("block result dropped while queue full");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

	localparam int WIDE = 80;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 24;
	localparam int END_CYCLES = 60;
	localparam int RANDOM_ITEMS = 1000;
	localparam logic signed [WIDE-1:0] Q_MAX = 80'sh7FFF_FFFF_FFFF;
	localparam logic signed [WIDE-1:0] Q_MIN = -Q_MAX - 80'sd1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic [gbm_pkg::SAMPLE_W-1:0] sample = '0;
	logic magnitude_valid;
	logic magnitude_ready = 1'b0;
	logic [gbm_pkg::MAG_W-1:0] magnitude;
	logic cfg_we = 1'b0;
	logic [gbm_pkg::CFG_IDX_W-1:0] cfg_index = gbm_pkg::CFG_BLOCK_LENGTH;
	logic [gbm_pkg::CFG_W-1:0] cfg_data = '0;

	goertzel_bin_magnitude_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.magnitude_valid(magnitude_valid),
		.magnitude_ready(magnitude_ready),
		.magnitude(magnitude),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// detector mirror: registers and recurrence state
	logic [gbm_pkg::BLEN_W-1:0] len_cfg = gbm_pkg::RST_BLOCK_LENGTH;
	logic signed [gbm_pkg::COEF_W-1:0] tcos_cfg = gbm_pkg::RST_TWO_COS;
	logic signed [gbm_pkg::SCOEF_W-1:0] cos_cfg = gbm_pkg::RST_COS;
	logic signed [gbm_pkg::SCOEF_W-1:0] sin_cfg = gbm_pkg::RST_SIN;
	logic signed [gbm_pkg::STATE_W-1:0] acc_n1 = '0;
	logic signed [gbm_pkg::STATE_W-1:0] acc_n2 = '0;
	int unsigned block_fill = 0;

	logic [gbm_pkg::SAMPLE_W-1:0] sample_backlog[$];
	logic [gbm_pkg::MAG_W-1:0] pending_mags[$];
	logic [gbm_pkg::MAG_W-1:0] mag_want;
	int unsigned pushed_count = 0;
	int unsigned accepted_count = 0;
	int errors = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit sample_taken = 1'b0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	// v * c / 2^14, rounded to nearest, ties up
	function automatic logic signed [WIDE-1:0] round_q14(logic signed [gbm_pkg::STATE_W-1:0] v,
			logic signed [gbm_pkg::COEF_W-1:0] c);
		logic signed [WIDE-1:0] p;
		p = WIDE'(v) * WIDE'(c);
		return (p + 80'sd8192) >>> 14;
	endfunction

	function automatic logic [gbm_pkg::MAG_W-1:0] floor_sqrt(logic [63:0] n);
		logic [63:0] root;
		logic [63:0] trial;
		root = '0;
		for (int i = 31; i >= 0; i--) begin
			trial = root | (64'd1 << i);
			if (trial * trial <= n)
				root = trial;
		end
		return root[gbm_pkg::MAG_W-1:0];
	endfunction

	function automatic logic [gbm_pkg::MAG_W-1:0] bin_magnitude(logic signed [WIDE-1:0] re,
			logic signed [WIDE-1:0] im);
		logic [WIDE-1:0] a;
		logic [WIDE-1:0] b;
		logic [WIDE-1:0] sum;
		a = re[WIDE-1] ? -re : re;
		b = im[WIDE-1] ? -im : im;
		if (a >= (80'd1 << 32) || b >= (80'd1 << 32))
			return '1;
		sum = a * a + b * b;
		if (sum >= (80'd1 << 64))
			return '1;
		return floor_sqrt(sum[63:0]);
	endfunction

	task automatic advance_goertzel(logic signed [gbm_pkg::SAMPLE_W-1:0] x);
		logic signed [WIDE-1:0] nxt;
		logic signed [WIDE-1:0] re;
		logic signed [WIDE-1:0] im;
		int unsigned eff_len;
		eff_len = 32'(len_cfg);
		if (eff_len < gbm_pkg::MIN_BLOCK_LENGTH)
			eff_len = gbm_pkg::MIN_BLOCK_LENGTH;
		if (eff_len > gbm_pkg::MAX_BLOCK_LENGTH)
			eff_len = gbm_pkg::MAX_BLOCK_LENGTH;
		nxt = round_q14(acc_n1, tcos_cfg) - WIDE'(acc_n2) + WIDE'(x);
		if (nxt > Q_MAX)
			nxt = Q_MAX;
		if (nxt < Q_MIN)
			nxt = Q_MIN;
		acc_n2 = acc_n1;
		acc_n1 = nxt[gbm_pkg::STATE_W-1:0];
		block_fill++;
		if (block_fill >= eff_len) begin
			re = WIDE'(acc_n1) - round_q14(acc_n2, gbm_pkg::COEF_W'(cos_cfg));
			im = round_q14(acc_n2, gbm_pkg::COEF_W'(sin_cfg));
			pending_mags = {pending_mags, bin_magnitude(re, im)};
			acc_n1 = '0;
			acc_n2 = '0;
			block_fill = 0;
		end
	endtask

	// sample driver
	always @(negedge clk) begin
		if (!sample_valid || sample_taken) begin
			if (arst_n && sample_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				sample_valid <= 1'b1;
				sample <= sample_backlog.pop_front();
			end else begin
				sample_valid <= 1'b0;
			end
		end
		sample_taken = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && sample_valid && sample_ready) begin
			sample_taken = 1'b1;
			accepted_count++;
			advance_goertzel($signed(sample));
		end
	end

	// result side: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			magnitude_ready <= 1'b0;
		end else begin
			magnitude_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && magnitude_valid && magnitude_ready) begin
			if (pending_mags.size() == 0) begin
				if (errors < 10)
					$display("unexpected magnitude transaction: %0d", magnitude);
				errors++;
			end else begin
				mag_want = pending_mags.pop_front();
				if (magnitude !== mag_want) begin
					if (errors < 10)
						$display("magnitude mismatch: expected %0d, got %0d", mag_want, magnitude);
					errors++;
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	task automatic push_sample(logic [gbm_pkg::SAMPLE_W-1:0] s);
		sample_backlog = {sample_backlog, s};
		pushed_count++;
	endtask

	task automatic settle(int tail);
		while (accepted_count != pushed_count || pending_mags.size() != 0)
			@(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	task automatic write_reg(logic [gbm_pkg::CFG_IDX_W-1:0] idx, logic [gbm_pkg::CFG_W-1:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		case (idx)
			gbm_pkg::CFG_BLOCK_LENGTH: len_cfg = d[gbm_pkg::BLEN_W-1:0];
			gbm_pkg::CFG_TWO_COS: tcos_cfg = d;
			gbm_pkg::CFG_COS: cos_cfg = d[gbm_pkg::SCOEF_W-1:0];
			gbm_pkg::CFG_SIN: sin_cfg = d[gbm_pkg::SCOEF_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Q14 coefficient with the bit above the field left random
	function automatic logic [gbm_pkg::CFG_W-1:0] random_coeff();
		int v;
		case ($urandom_range(5))
			0: v = 32767;
			1: v = -32768;
			default: v = $urandom_range(32768) - 16384;
		endcase
		return {1'($urandom_range(1)), 16'(v)};
	endfunction

	initial begin
		int seg;
		int rand_items;
		int seg_len;
		int r;
		int v;
		logic [gbm_pkg::BLEN_W-1:0] blen;
		logic [gbm_pkg::CFG_W-1:0] d;
		logic [gbm_pkg::SAMPLE_W-1:0] s;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// partial block on reset settings, then shorten the block under it
		push_sample(16'h7FFF);
		push_sample(16'h8000);
		push_sample(16'h0000);
		push_sample(16'hFFFF);
		settle(SETTLE_CYCLES);
		write_reg(gbm_pkg::CFG_BLOCK_LENGTH, 17'd3);
		push_sample(16'h5555);
		settle(SETTLE_CYCLES);

		// near-4.0 feedback drives the state into saturation
		write_reg(gbm_pkg::CFG_TWO_COS, 17'h0FFFF);
		write_reg(gbm_pkg::CFG_COS, 17'h07FFF);
		write_reg(gbm_pkg::CFG_SIN, 17'h08000);
		write_reg(gbm_pkg::CFG_BLOCK_LENGTH, 17'd20);
		repeat (20) push_sample(16'h7FFF);
		settle(SETTLE_CYCLES);

		seg = 0;
		rand_items = 0;
		while (rand_items < RANDOM_ITEMS) begin
			if (rand_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 29;
				recv_idle_pct = 71;
			end else if (rand_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 71;
				recv_idle_pct = 29;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			r = $urandom_range(9);
			if (seg == 3)
				blen = 13'($urandom_range(3, 2));
			else if (r < 6)
				blen = 13'($urandom_range(24, 2));
			else if (r == 6)
				blen = 13'($urandom_range(1));
			else if (r == 7)
				blen = 13'($urandom_range(300, 25));
			else if (r == 8)
				blen = $urandom_range(1) ? 13'd4096 : 13'd8191;
			else
				blen = 13'($urandom_range(8191, 4097));
			write_reg(gbm_pkg::CFG_BLOCK_LENGTH, {4'($urandom_range(15)), blen});

			case ($urandom_range(7))
				0: d = 17'h0FFFF;
				1: d = 17'h10000;
				2: d = 17'h08000;
				3: d = 17'h18000;
				default: begin
					v = $urandom_range(65536) - 32768;
					d = 17'(v);
				end
			endcase
			write_reg(gbm_pkg::CFG_TWO_COS, d);
			write_reg(gbm_pkg::CFG_COS, random_coeff());
			write_reg(gbm_pkg::CFG_SIN, random_coeff());

			// short blocks plus a long output stall back up into the sample port
			if (seg == 3) begin
				hold_req = 1'b1;
				seg_len = 80;
			end else begin
				seg_len = $urandom_range(80, 20);
			end

			repeat (seg_len) begin
				r = $urandom_range(9);
				if (r < 6) begin
					s = 16'($urandom);
				end else if (r < 8) begin
					v = $urandom_range(512) - 256;
					s = 16'(v);
				end else begin
					case ($urandom_range(3))
						0: s = 16'h7FFF;
						1: s = 16'h8000;
						2: s = 16'h0000;
						default: s = 16'hFFFF;
					endcase
				end
				push_sample(s);
			end
			rand_items += seg_len;
			seg++;
			settle(SETTLE_CYCLES);
		end

		settle(END_CYCLES);
		if (errors == 0 && pending_mags.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[files.f]
design/gbm_pkg.sv
design/gbm_front.sv
design/gbm_fifo.sv
design/gbm_back.sv
design/goertzel_bin_magnitude_core.sv
tb/sv/tb.sv
